// ----- rtl/mrd_pkg.sv -----
// shared types, constants and crc function for the modbus register response deframer
`timescale 1ns / 1ps
package mrd_pkg;

  typedef enum logic [2:0] {
    PH_ADDR,
    PH_FUNC,
    PH_COUNT,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  typedef enum logic [1:0] {
    CFG_SLAVE_ADDRESS     = 2'd0,
    CFG_EXPECTED_FUNCTION = 2'd1,
    CFG_VALUE_OFFSET      = 2'd2
  } cfg_index_t;

  localparam logic [7:0]  SLAVE_ADDRESS_RESET     = 8'h01;
  localparam logic [7:0]  EXPECTED_FUNCTION_RESET = 8'h04;
  localparam logic [15:0] VALUE_OFFSET_RESET      = 16'd2000;
  localparam logic [15:0] CRC_INIT                = 16'hFFFF;
  localparam logic [15:0] CRC_POLY                = 16'hA001;

  // crc-16/modbus, one byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/mrd_if.sv -----
// stream interfaces for received bytes and register results
`timescale 1ns / 1ps
interface mrd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrd_reg_if;
  logic               valid;
  logic               ready;
  logic [2:0]         reg_index;
  logic signed [16:0] reg_value;
  logic               last;
  modport source (output valid, output reg_index, output reg_value, output last, input ready);
  modport sink (input valid, input reg_index, input reg_value, input last, output ready);
endinterface

// ----- rtl/modbus_register_response_deframer.sv -----
// top level of the modbus register response deframer
//
//   channel   dir   handshake          payload
//   rx        in    valid / ready      rx_byte[7:0]
//   res       out   valid / ready      reg_index[2:0], reg_value[16:0] signed, last
//   config    in    wr_en              wr_index[1:0], wr_data[15:0]
//
// one byte is taken per cycle while rx.ready is high; the crc update runs in the same cycle as the byte
// results leave the emitter's output register one per cycle while res.ready is high, REG_COUNT per good frame
// the parser stalls only on the final crc byte of any frame while both queue slots are full
// synchronous reset returns to the address hunt with crc 0xffff and config at defaults
`timescale 1ns / 1ps
module modbus_register_response_deframer #(
  parameter int REG_COUNT = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  mrd_rx_if.sink      rx,
  mrd_reg_if.source   res
);

  logic [7:0]  slave_address;
  logic [7:0]  expected_function;
  logic [15:0] value_offset;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic [REG_COUNT-1:0][15:0] q_data;
  logic [REG_COUNT-1:0][15:0] q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address     <= mrd_pkg::SLAVE_ADDRESS_RESET;
      expected_function <= mrd_pkg::EXPECTED_FUNCTION_RESET;
      value_offset      <= mrd_pkg::VALUE_OFFSET_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        mrd_pkg::CFG_SLAVE_ADDRESS:     slave_address     <= wr_data[7:0];
        mrd_pkg::CFG_EXPECTED_FUNCTION: expected_function <= wr_data[7:0];
        mrd_pkg::CFG_VALUE_OFFSET:      value_offset      <= wr_data;
        default: ;
      endcase
    end
  end

  mrd_front #(.REG_COUNT(REG_COUNT)) u_front (
    .clk               (clk),
    .rst               (rst),
    .rx                (rx),
    .slave_address     (slave_address),
    .expected_function (expected_function),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (q_data)
  );

  mrd_queue #(.REG_COUNT(REG_COUNT)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  mrd_back #(.REG_COUNT(REG_COUNT)) u_back (
    .clk          (clk),
    .rst          (rst),
    .value_offset (value_offset),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .res          (res)
  );

endmodule

// ----- rtl/mrd_front.sv -----
// frame parser: header hunt, register collection and crc check
`timescale 1ns / 1ps
module mrd_front #(
  parameter int REG_COUNT = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  mrd_rx_if.sink                     rx,
  input  logic [7:0]                 slave_address,
  input  logic [7:0]                 expected_function,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [REG_COUNT-1:0][15:0] q_data
);

  localparam int IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(REG_COUNT - 1);
  localparam logic [7:0] CountByte = 8'(2 * REG_COUNT);

  mrd_pkg::phase_t phase, phase_next;
  logic [15:0] crc, crc_next;
  logic [IW-1:0] widx, widx_next;
  logic half, half_next;
  logic [7:0] hi_byte;
  logic [7:0] crc_lo;
  logic [REG_COUNT-1:0][15:0] store;

  logic accept;
  logic hunt_hit;
  logic [15:0] hunt_crc;
  logic [15:0] byte_crc;
  logic crc_ok;

  assign hunt_hit = (rx.rx_byte == slave_address);
  assign hunt_crc = mrd_pkg::crc_step(mrd_pkg::CRC_INIT, rx.rx_byte);
  assign byte_crc = mrd_pkg::crc_step(crc, rx.rx_byte);

  // next state
  always_comb begin
    phase_next = phase;
    crc_next   = crc;
    widx_next  = widx;
    half_next  = half;
    unique case (phase)
      mrd_pkg::PH_FUNC: begin
        if (rx.rx_byte == expected_function) begin
          crc_next   = byte_crc;
          phase_next = mrd_pkg::PH_COUNT;
        end else begin
          phase_next = hunt_hit ? mrd_pkg::PH_FUNC : mrd_pkg::PH_ADDR;
          crc_next   = hunt_hit ? hunt_crc : mrd_pkg::CRC_INIT;
        end
      end
      mrd_pkg::PH_COUNT: begin
        if (rx.rx_byte == CountByte) begin
          crc_next   = byte_crc;
          widx_next  = '0;
          half_next  = 1'b0;
          phase_next = mrd_pkg::PH_DATA;
        end else begin
          phase_next = hunt_hit ? mrd_pkg::PH_FUNC : mrd_pkg::PH_ADDR;
          crc_next   = hunt_hit ? hunt_crc : mrd_pkg::CRC_INIT;
        end
      end
      mrd_pkg::PH_DATA: begin
        crc_next  = byte_crc;
        half_next = ~half;
        if (half) begin
          if (widx == LastIdx) begin
            widx_next  = '0;
            phase_next = mrd_pkg::PH_CRC_LO;
          end else begin
            widx_next = widx + 1'b1;
          end
        end
      end
      mrd_pkg::PH_CRC_LO: begin
        phase_next = mrd_pkg::PH_CRC_HI;
      end
      mrd_pkg::PH_CRC_HI: begin
        phase_next = mrd_pkg::PH_ADDR;
        crc_next   = mrd_pkg::CRC_INIT;
        widx_next  = '0;
        half_next  = 1'b0;
      end
      default: begin
        phase_next = hunt_hit ? mrd_pkg::PH_FUNC : mrd_pkg::PH_ADDR;
        crc_next   = hunt_hit ? hunt_crc : mrd_pkg::CRC_INIT;
        widx_next  = '0;
        half_next  = 1'b0;
      end
    endcase
  end

  // outputs
  always_comb begin
    crc_ok   = (crc_lo == crc[7:0]) && (rx.rx_byte == crc[15:8]);
    rx.ready = !((phase == mrd_pkg::PH_CRC_HI) && q_full);
    accept   = rx.valid && rx.ready;
    q_push   = accept && (phase == mrd_pkg::PH_CRC_HI) && crc_ok;
    q_data   = store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mrd_pkg::PH_ADDR;
      crc   <= mrd_pkg::CRC_INIT;
      widx  <= '0;
      half  <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      crc   <= crc_next;
      widx  <= widx_next;
      half  <= half_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase == mrd_pkg::PH_DATA)) begin
      if (half) begin
        store[widx] <= {hi_byte, rx.rx_byte};
      end else begin
        hi_byte <= rx.rx_byte;
      end
    end
    if (accept && (phase == mrd_pkg::PH_CRC_LO)) begin
      crc_lo <= rx.rx_byte;
    end
  end

endmodule

// ----- rtl/mrd_queue.sv -----
// two-entry queue of checked frames
`timescale 1ns / 1ps
module mrd_queue #(
  parameter int REG_COUNT = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [REG_COUNT-1:0][15:0] push_data,
  output logic                       full,
  input  logic                       pop,
  output logic                       empty,
  output logic [REG_COUNT-1:0][15:0] head
);

  logic [REG_COUNT-1:0][15:0] entry [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/mrd_back.sv -----
// result emitter: one register word per transfer, offset removed
`timescale 1ns / 1ps
module mrd_back #(
  parameter int REG_COUNT = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [15:0]                value_offset,
  input  logic                       q_empty,
  input  logic [REG_COUNT-1:0][15:0] q_head,
  output logic                       q_pop,
  mrd_reg_if.source                  res
);

  localparam int IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(REG_COUNT - 1);

  logic [IW-1:0] idx;
  logic out_valid;
  logic [2:0] out_index;
  logic signed [16:0] out_value;
  logic out_last;
  logic load;
  logic emit;

  assign load  = !out_valid || res.ready;
  assign emit  = load && !q_empty;
  assign q_pop = emit && (idx == LastIdx);

  assign res.valid     = out_valid;
  assign res.reg_index = out_index;
  assign res.reg_value = out_value;
  assign res.last      = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (emit) begin
        idx <= (idx == LastIdx) ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index <= 3'(idx);
      out_value <= $signed({1'b0, q_head[idx]} - {1'b0, value_offset});
      out_last  <= (idx == LastIdx);
    end
  end

endmodule

// ----- rtl/mrd_checker.sv -----
// port-level checks for the modbus register response deframer
`timescale 1ns / 1ps
module mrd_checker #(
  parameter int REG_COUNT = 7
) (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [2:0]         res_reg_index,
  input logic signed [16:0] res_reg_value,
  input logic               res_last
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_reg_index)
      && $stable(res_reg_value) && $stable(res_last))
    else $error("result changed while stalled");

  // last marks the final register index
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_last == (res_reg_index == 3'(REG_COUNT - 1))))
    else $error("last flag does not match register index");

  // a frame's results follow without gaps once started
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=> res_valid
      && (res_reg_index == $past(res_reg_index) + 3'd1))
    else $error("gap or wrong order inside a frame");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind modbus_register_response_deframer mrd_checker #(.REG_COUNT(REG_COUNT)) u_mrd_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_reg_index (res.reg_index),
  .res_reg_value (res.reg_value),
  .res_last      (res.last)
);
